// File: sv/nnf_pkg.sv
// Shared types and constants for the nearest note finder.
// No dependencies; imported by every module of the block except nnf_fifo.
package nnf_pkg;

  localparam int FREQ_FRACTION_BITS = 16;
  localparam logic [31:0] REF_RESET = 32'(440) << FREQ_FRACTION_BITS;

  localparam int LOG_FRAC  = 24;
  localparam int MANT_W    = 32;
  localparam int POS_W     = 5;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 32;

  typedef struct packed {
    logic              zero;
    logic [POS_W-1:0]  pos_f;
    logic [POS_W-1:0]  pos_r;
    logic [MANT_W-1:0] freq;
    logic [MANT_W-1:0] refq;
  } front_item_t;

  typedef struct packed {
    logic [3:0]         note_index;
    logic signed [5:0]  octave_offset;
    logic signed [10:0] cents_off;
    logic               result_valid;
  } result_t;

endpackage

// File: sv/nearest_note_finder_core.sv
// Top level of the nearest note finder: config register, queues, front and back.
// Depends on nnf_pkg, nnf_fifo, nnf_front and nnf_back.
//
// Takes one frequency (unsigned Q16.16 Hz) per clock while in_full is low and
// returns, in order, the nearest equal-tempered note (C = 0 .. B = 11, sharps
// named), its octave relative to the octave of the reference A (C below A up to B
// above it), and the deviation in 1/16 cent. A zero frequency or zero reference
// gives an all-zero result with result_valid low. Throughput is one item per
// cycle while in_full is low. An accepted item passes through the middle queue,
// the log2 pipeline (normalize plus 24 squaring stages), the difference, cents
// scaling and octave split stages, the note-pick register and the write into the
// result queue before it shows on the out_ ports. The result queue holds 32 items,
// and the back end admits an item only while it has a free slot there, so a
// stalled reader fills the queues and then raises in_full. Write the reference
// only while no item is in flight; cfg_ready is always high.
module nearest_note_finder_core #(
  parameter int CENT_FRACTION_BITS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [31:0]        in_measured_freq,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [3:0]         out_note_index,
  output logic signed [5:0]  out_octave_offset,
  output logic signed [10:0] out_cents_off,
  output logic               out_result_valid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_reference_freq
);
  import nnf_pkg::*;

  logic [31:0] ref_r;
  front_item_t fr_item, mid_item;
  logic        mid_full, mid_empty, mid_take;
  logic        res_push, out_full;
  result_t     res, head;

  // Hold the reference; accept writes at any time.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n)         ref_r <= REF_RESET;
    else if (cfg_valid) ref_r <= cfg_reference_freq;
  end

  // Classify the incoming item against the current reference.
  nnf_front u_front (
    .measured_freq  (in_measured_freq),
    .reference_freq (ref_r),
    .item           (fr_item)
  );

  // Decouple front from back so either side can stall.
  nnf_fifo #(.W($bits(front_item_t)), .D(MID_DEPTH)) u_mid (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (fr_item),
    .pop   (mid_take),
    .rdata (mid_item),
    .full  (mid_full),
    .empty (mid_empty)
  );
  assign in_full = mid_full;

  // Advance items through the log and note pipeline.
  nnf_back #(.CENT_FRACTION_BITS(CENT_FRACTION_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (mid_item),
    .item_avail (!mid_empty),
    .item_take  (mid_take),
    .res_taken  (out_pop && !out_empty),
    .res_push   (res_push),
    .res        (res)
  );

  // Queue results for the reader.
  nnf_fifo #(.W($bits(result_t)), .D(OUT_DEPTH)) u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .pop   (out_pop),
    .rdata (head),
    .full  (out_full),
    .empty (out_empty)
  );

  assign out_note_index    = head.note_index;
  assign out_octave_offset = head.octave_offset;
  assign out_cents_off     = head.cents_off;
  assign out_result_valid  = head.result_valid;

  // Credit scheme must never overrun the result queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_push && out_full))
    else $error("result queue overflow");

  // Invalid results carry zero fields.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_result_valid) |->
      (out_note_index == 4'd0 && out_octave_offset == 6'sd0 && out_cents_off == 11'sd0))
    else $error("invalid result with nonzero fields");

  // Note index stays within one octave.
  a_note_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_note_index <= 4'd11))
    else $error("note index out of range");
endmodule

// File: sv/nnf_fifo.sv
// Small register-based queue, generic width and depth.
// No dependencies.
module nnf_fifo #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  localparam int AW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  logic [W-1:0]  mem_r [D];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(D));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == AW'(D - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == AW'(D - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
    if (do_push) mem_r[wp_r] <= wdata;
  end
endmodule

// File: sv/nnf_front.sv
// Front end: flags invalid items and finds the leading one of both operands.
// Depends on nnf_pkg.
module nnf_front (
  input  logic [31:0]         measured_freq,
  input  logic [31:0]         reference_freq,
  output nnf_pkg::front_item_t item
);
  import nnf_pkg::*;

  function automatic logic [POS_W-1:0] lead_one(input logic [MANT_W-1:0] v);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = 1; i < MANT_W; i++) begin
      if (v[i]) p = POS_W'(i);
    end
    return p;
  endfunction

  always_comb begin
    item.zero  = (measured_freq == '0) || (reference_freq == '0);
    item.pos_f = lead_one(measured_freq);
    item.pos_r = lead_one(reference_freq);
    item.freq  = measured_freq;
    item.refq  = reference_freq;
  end
endmodule

// File: sv/nnf_back.sv
// Back end: log2 squaring pipeline, cents scaling, octave split and note pick.
// Depends on nnf_pkg. Free-running; admission is gated by an output credit count.
module nnf_back #(
  parameter int CENT_FRACTION_BITS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  nnf_pkg::front_item_t item,
  input  logic                 item_avail,
  output logic                 item_take,
  input  logic                 res_taken,
  output logic                 res_push,
  output nnf_pkg::result_t     res
);
  import nnf_pkg::*;

  localparam int SEMI  = 100 << CENT_FRACTION_BITS;
  localparam int OCT   = 1200 << CENT_FRACTION_BITS;
  localparam int HALF  = SEMI / 2;
  localparam int OW    = $clog2(OCT + 1) + 1;
  localparam int UW    = $clog2(OCT + 1);
  localparam int DW    = 30;
  localparam int PW    = DW + OW + 1;
  localparam int CW    = PW - LOG_FRAC;
  localparam int OCT_BIAS  = 33;
  localparam int NOTE_BIAS = 9;
  localparam int BIAS  = NOTE_BIAS * SEMI + OCT_BIAS * OCT;
  localparam int XW    = $clog2(66 * OCT + NOTE_BIAS * SEMI + 1);
  localparam int YW    = 17;
  localparam int RSH   = 30;
  localparam int RECIP = (2 ** RSH + 1199) / 1200;
  localparam int RCW   = 20;
  localparam int QPW   = YW + RCW;
  localparam int RW    = XW + 2;
  localparam int CRW   = $clog2(OUT_DEPTH + 1);

  // Credits: items in flight plus results queued downstream.
  logic [CRW-1:0] credit_r;
  assign item_take = item_avail && (credit_r < CRW'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) credit_r <= '0;
    else        credit_r <= credit_r + CRW'(item_take) - CRW'(res_taken);
  end

  // Log pipeline stage registers; index 0 holds the normalized mantissas.
  logic              v_r    [LOG_FRAC+1];
  logic              z_r    [LOG_FRAC+1];
  logic [POS_W-1:0]  pf_r   [LOG_FRAC+1];
  logic [POS_W-1:0]  pr_r   [LOG_FRAC+1];
  logic [MANT_W-1:0] mf_r   [LOG_FRAC+1];
  logic [MANT_W-1:0] mr_r   [LOG_FRAC+1];
  logic [LOG_FRAC-1:0] ff_r [LOG_FRAC+1];
  logic [LOG_FRAC-1:0] fr_r [LOG_FRAC+1];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else        v_r[0] <= item_take;
    z_r[0]  <= item.zero;
    pf_r[0] <= item.pos_f;
    pr_r[0] <= item.pos_r;
    mf_r[0] <= item.freq << (POS_W'(MANT_W - 1) - item.pos_f);
    mr_r[0] <= item.refq << (POS_W'(MANT_W - 1) - item.pos_r);
    ff_r[0] <= '0;
    fr_r[0] <= '0;
  end

  for (genvar g = 0; g < LOG_FRAC; g++) begin : g_log
    logic [2*MANT_W-1:0] sqf, sqr;
    always_comb begin
      sqf = mf_r[g] * mf_r[g];
      sqr = mr_r[g] * mr_r[g];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[g+1] <= 1'b0;
      else        v_r[g+1] <= v_r[g];
      z_r[g+1]  <= z_r[g];
      pf_r[g+1] <= pf_r[g];
      pr_r[g+1] <= pr_r[g];
      mf_r[g+1] <= sqf[63] ? sqf[63:32] : sqf[62:31];
      mr_r[g+1] <= sqr[63] ? sqr[63:32] : sqr[62:31];
      ff_r[g+1] <= {ff_r[g][LOG_FRAC-2:0], sqf[63]};
      fr_r[g+1] <= {fr_r[g][LOG_FRAC-2:0], sqr[63]};
    end
  end

  // Post-log stages A..E.
  logic                 va_r, vb_r, vc_r, vd_r;
  logic                 za_r, zb_r, zc_r, zd_r;
  logic signed [DW-1:0] d_r;
  logic signed [CW-1:0] cents_r;
  logic [XW-1:0]        xc_r;
  logic [QPW-1:0]       qp_r;
  logic [UW-1:0]        r_r;
  logic [6:0]           q_r;

  logic signed [PW-1:0] prod;
  logic signed [CW:0]   xs;
  logic [YW-1:0]        y;
  logic [6:0]           q_est;
  logic signed [RW-1:0] rem;

  always_comb begin
    prod  = PW'(d_r) * PW'(OCT) + PW'(1 << (LOG_FRAC - 1));
    xs    = (CW + 1)'(cents_r) + (CW + 1)'(BIAS);
    y     = YW'(xs[XW-1:0] >> CENT_FRACTION_BITS);
    q_est = qp_r[QPW-1:RSH];
    rem   = $signed({2'b00, xc_r}) - $signed(RW'(q_est) * RW'(OCT));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      va_r <= v_r[LOG_FRAC];
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
    za_r <= z_r[LOG_FRAC];
    d_r  <= $signed({1'b0, pf_r[LOG_FRAC], ff_r[LOG_FRAC]})
          - $signed({1'b0, pr_r[LOG_FRAC], fr_r[LOG_FRAC]});
    zb_r    <= za_r;
    cents_r <= prod[PW-1:LOG_FRAC];
    zc_r <= zb_r;
    xc_r <= xs[XW-1:0];
    qp_r <= QPW'(y) * QPW'(RECIP);
    zd_r <= zc_r;
    if (rem < 0) begin
      q_r <= q_est - 7'd1;
      r_r <= UW'(rem + RW'(OCT));
    end else begin
      q_r <= q_est;
      r_r <= UW'(rem);
    end
  end

  // Stage E: nearest semitone, ties to the lower one.
  logic [UW:0]          t;
  logic [3:0]           j;
  logic signed [UW+1:0] dev;
  logic                 wrap;
  logic signed [7:0]    oct;
  result_t              res_nxt;

  always_comb begin
    t = (UW + 1)'(r_r) + (UW + 1)'(HALF - 1);
    j = '0;
    for (int k = 1; k <= 12; k++) begin
      if (t >= (UW + 1)'(k * SEMI)) j = j + 4'd1;
    end
    dev  = $signed((UW + 2)'(r_r)) - $signed((UW + 2)'(j) * (UW + 2)'(SEMI));
    wrap = (j == 4'd12);
    oct  = $signed({1'b0, q_r}) - 8'(OCT_BIAS) + 8'(wrap);
    res_nxt.note_index   = wrap ? 4'd0 : j;
    res_nxt.cents_off    = 11'(dev);
    res_nxt.result_valid = 1'b1;
    if (oct < -8'sd32)     res_nxt.octave_offset = -6'sd32;
    else if (oct > 8'sd31) res_nxt.octave_offset = 6'sd31;
    else                   res_nxt.octave_offset = 6'(oct);
    if (zd_r) res_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) res_push <= 1'b0;
    else        res_push <= vd_r;
    res <= res_nxt;
  end
endmodule
